### design/rlcm_pkg.sv
// Package for the rational lcm block: payload structs, controller states,
// and the command/status structs that join controller and datapath.
// No dependencies.
package rlcm_pkg;

	localparam int unsigned FW = 32;

	typedef struct packed {
		logic [FW-1:0] x_numerator;
		logic [FW-1:0] x_denominator;
		logic [FW-1:0] y_numerator;
		logic [FW-1:0] y_denominator;
	} rlcm_in_t;

	typedef struct packed {
		logic [FW-1:0] lcm_numerator;
		logic [FW-1:0] lcm_denominator;
		logic          overflow;
	} rlcm_out_t;

	// Operation selects for the datapath
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_GCD_START,
		OP_GCD_STEP,
		OP_DIV_START,
		OP_DIV_STEP,
		OP_MUL,
		OP_COPY
	} rlcm_op_t;

	// Which phase of the sequence the datapath works on
	typedef enum logic [2:0] {
		PH_XRED,
		PH_YRED,
		PH_NUMG,
		PH_NUM,
		PH_DEN
	} rlcm_phase_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_GCD_INIT,
		ST_GCD_RUN,
		ST_DIV1_INIT,
		ST_DIV1_RUN,
		ST_DIV2_INIT,
		ST_DIV2_RUN,
		ST_MUL,
		ST_DONE
	} rlcm_state_t;

	typedef struct packed {
		rlcm_op_t    op;
		rlcm_phase_t phase;
		logic        second;   // second divide of a reduction
	} rlcm_cmd_t;

	typedef struct packed {
		logic gcd_done;
		logic div_done;
		logic zero_case;
	} rlcm_sts_t;

endpackage

### design/rational_lcm.sv
// Top level of the rational lcm block: controller, datapath and the
// result register. Depends on rlcm_pkg, rlcm_ctrl, rlcm_datapath.
//
//  channel | signals                       | payload
//  in      | in_valid / in_ready           | rlcm_in_t  (a/b, c/d)
//  out     | out_valid / out_ready         | rlcm_out_t (N/D, overflow)
//
// One item at a time. Each item runs four gcd passes and five divides
// through one shared shift-subtract unit, plus one multiply. The run
// time is set by the Euclid step counts.
// A zero numerator skips the gcd and divide steps. The result register frees the
// core as soon as out is free: a new item is accepted while the result waits.
// Reset clears control state only.
module rational_lcm #(
	parameter int unsigned WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rlcm_pkg::rlcm_in_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output rlcm_pkg::rlcm_out_t out_item
);
	import rlcm_pkg::*;

	rlcm_cmd_t cmd;
	rlcm_sts_t sts;
	rlcm_out_t res;
	logic      busy, finish, out_free, start;

	assign in_ready = !busy;
	assign start    = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;

	rlcm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .out_free(out_free),
		.sts(sts), .cmd(cmd), .busy(busy), .finish(finish)
	);

	rlcm_datapath #(.WIDTH(WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .cmd(cmd),
		.sts(sts), .res(res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (finish && out_free) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish && out_free) out_item <= res;
	end

	// A new item is never taken while the core works
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !start) else $error("item accepted while busy");
	// A result is only loaded when the output side is free
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && out_valid && !out_ready) |=> out_valid)
		else $error("result lost");
	// Denominator of a produced result is never zero
	a_den_nz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.lcm_denominator != '0))
		else $error("zero denominator");

endmodule

### design/rlcm_datapath.sv
// Datapath of the rational lcm block: operand registers, a shared
// subtract-and-shift divider/remainder unit, and a WIDTHxWIDTH multiplier.
// Depends on rlcm_pkg.
module rlcm_datapath #(
	parameter int unsigned WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rlcm_pkg::rlcm_in_t in_item,
	input  rlcm_pkg::rlcm_cmd_t cmd,
	output rlcm_pkg::rlcm_sts_t sts,
	output rlcm_pkg::rlcm_out_t res
);
	import rlcm_pkg::*;

	localparam int unsigned CW = $clog2(WIDTH + 1);

	// Operands and intermediate values (all fit in WIDTH bits but num)
	logic [WIDTH-1:0]   a_q, b_q, c_q, d_q, g_q, den_q;
	logic [2*WIDTH-1:0] num_q;
	// gcd registers
	logic [WIDTH-1:0]   gp_q, gq_q;
	// divider registers: quotient/dividend shift, partial remainder
	logic [WIDTH-1:0]   dq_q, dr_q, dv_q;
	logic [CW-1:0]      cnt_q;
	logic               zero_q;
	logic               in_gcd_q;

	logic [WIDTH-1:0] in_a, in_b, in_c, in_d;
	assign in_a = in_item.x_numerator[WIDTH-1:0];
	assign in_b = (in_item.x_denominator[WIDTH-1:0] == '0) ? WIDTH'(1)
		: in_item.x_denominator[WIDTH-1:0];
	assign in_c = in_item.y_numerator[WIDTH-1:0];
	assign in_d = (in_item.y_denominator[WIDTH-1:0] == '0) ? WIDTH'(1)
		: in_item.y_denominator[WIDTH-1:0];

	// One restoring-division step
	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   rem_sh;
	assign rem_sh = {dr_q, dq_q[WIDTH-1]};
	assign trial  = rem_sh - {1'b0, dv_q};

	// Gcd operands picked by phase
	logic [WIDTH-1:0] gp_src, gq_src;
	always_comb begin
		case (cmd.phase)
			PH_XRED: begin gp_src = a_q; gq_src = b_q; end
			PH_YRED: begin gp_src = c_q; gq_src = d_q; end
			PH_NUMG: begin gp_src = a_q; gq_src = c_q; end
			default: begin gp_src = b_q; gq_src = d_q; end
		endcase
	end

	// Dividend for a divide, by phase and which divide
	logic [WIDTH-1:0] div_src;
	always_comb begin
		case (cmd.phase)
			PH_XRED: div_src = cmd.second ? b_q : a_q;
			PH_YRED: div_src = cmd.second ? d_q : c_q;
			default: div_src = a_q;
		endcase
	end

	logic [WIDTH-1:0] quot;
	assign quot = dq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			zero_q   <= 1'b0;
			in_gcd_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					zero_q <= (in_a == '0) || (in_c == '0);
				end
				OP_GCD_START: begin
					in_gcd_q <= 1'b1;
					cnt_q    <= CW'(WIDTH);
				end
				OP_GCD_STEP: begin
					// a remainder divide runs inside each gcd step
					if (cnt_q == '0) begin
						cnt_q <= CW'(WIDTH);
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				OP_DIV_START: begin
					in_gcd_q <= 1'b0;
					cnt_q    <= CW'(WIDTH);
				end
				OP_DIV_STEP: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				a_q <= in_a;
				b_q <= in_b;
				c_q <= in_c;
				d_q <= in_d;
			end
			OP_GCD_START: begin
				gp_q <= gp_src;
				gq_q <= gq_src;
				// first remainder: gp mod gq
				dq_q <= gp_src;
				dr_q <= '0;
				dv_q <= gq_src;
			end
			OP_GCD_STEP: begin
				if (gq_q != '0) begin
					if (cnt_q != '0) begin
						dq_q <= {dq_q[WIDTH-2:0], ~trial[WIDTH]};
						dr_q <= trial[WIDTH] ? rem_sh[WIDTH-1:0] : trial[WIDTH-1:0];
					end else begin
						// remainder in dr_q: rotate
						gp_q <= gq_q;
						gq_q <= dr_q;
						dq_q <= gq_q;
						dr_q <= '0;
						dv_q <= dr_q;
					end
				end
				g_q <= gp_q;
			end
			OP_DIV_START: begin
				dq_q <= div_src;
				dr_q <= '0;
				dv_q <= g_q;
			end
			OP_DIV_STEP: begin
				if (cnt_q != '0) begin
					dq_q <= {dq_q[WIDTH-2:0], ~trial[WIDTH]};
					dr_q <= trial[WIDTH] ? rem_sh[WIDTH-1:0] : trial[WIDTH-1:0];
				end
			end
			OP_COPY: begin
				// store the finished quotient, or in the den phase the gcd
				case (cmd.phase)
					PH_XRED: if (cmd.second) b_q <= quot; else a_q <= quot;
					PH_YRED: if (cmd.second) d_q <= quot; else c_q <= quot;
					PH_NUMG: a_q <= quot;
					default: den_q <= g_q;
				endcase
			end
			OP_MUL: begin
				num_q <= a_q * c_q;
			end
			default: ;
		endcase
	end

	assign sts.gcd_done  = in_gcd_q && (gq_q == '0);
	assign sts.div_done  = (cnt_q == '0);
	assign sts.zero_case = zero_q;

	logic ovf;
	assign ovf = (num_q[2*WIDTH-1:WIDTH] != '0);

	always_comb begin
		res = '0;
		if (zero_q) begin
			res.lcm_denominator = FW'(1);
		end else begin
			res.lcm_numerator   = FW'(num_q[WIDTH-1:0]);
			res.lcm_denominator = FW'(den_q);
			res.overflow        = ovf;
		end
	end

endmodule

### design/rlcm_ctrl.sv
// Controller of the rational lcm block: sequences the gcd, divide and
// multiply steps over the phases. Depends on rlcm_pkg.
module rlcm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               out_free,
	input  rlcm_pkg::rlcm_sts_t sts,
	output rlcm_pkg::rlcm_cmd_t cmd,
	output logic               busy,
	output logic               finish
);
	import rlcm_pkg::*;

	rlcm_state_t state_q, state_d;
	rlcm_phase_t phase_q, phase_d;

	// Next state
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		unique case (state_q)
			ST_IDLE: if (start) state_d = ST_LOAD;
			ST_LOAD: begin
				phase_d = PH_XRED;
				state_d = ST_GCD_INIT;
			end
			ST_GCD_INIT: begin
				if (sts.zero_case) state_d = ST_DONE;
				else state_d = ST_GCD_RUN;
			end
			ST_GCD_RUN: begin
				if (sts.gcd_done) begin
					unique case (phase_q)
						PH_XRED, PH_YRED, PH_NUMG: state_d = ST_DIV1_INIT;
						default: state_d = ST_DIV2_RUN; // den: copy gcd
					endcase
				end
			end
			ST_DIV1_INIT: state_d = ST_DIV1_RUN;
			ST_DIV1_RUN: begin
				if (sts.div_done) begin
					if (phase_q == PH_NUMG) state_d = ST_MUL;
					else state_d = ST_DIV2_INIT;
				end
			end
			ST_DIV2_INIT: state_d = ST_DIV2_RUN;
			ST_DIV2_RUN: begin
				if (phase_q == PH_DEN) begin
					state_d = ST_DONE;
				end else if (sts.div_done) begin
					state_d = ST_GCD_INIT;
					phase_d = (phase_q == PH_XRED) ? PH_YRED : PH_NUMG;
				end
			end
			ST_MUL: begin
				state_d = ST_GCD_INIT;
				phase_d = PH_DEN;
			end
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_XRED;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	// Outputs
	always_comb begin
		cmd.op     = OP_NONE;
		cmd.phase  = phase_q;
		cmd.second = 1'b0;
		busy       = 1'b1;
		finish     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) cmd.op = OP_LOAD;
			end
			ST_LOAD: cmd.op = OP_NONE;
			ST_GCD_INIT: cmd.op = OP_GCD_START;
			ST_GCD_RUN: cmd.op = OP_GCD_STEP;
			ST_DIV1_INIT: cmd.op = OP_DIV_START;
			ST_DIV1_RUN: cmd.op = sts.div_done ? OP_COPY : OP_DIV_STEP;
			ST_DIV2_INIT: begin
				cmd.op     = OP_DIV_START;
				cmd.second = 1'b1;
			end
			ST_DIV2_RUN: begin
				cmd.second = 1'b1;
				if (phase_q == PH_DEN) cmd.op = OP_COPY;
				else cmd.op = sts.div_done ? OP_COPY : OP_DIV_STEP;
			end
			ST_MUL: cmd.op = OP_MUL;
			ST_DONE: finish = 1'b1;
			default: ;
		endcase
	end

endmodule
